>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the tinted layer blend unit.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/tlab_pkg.sv
// Package of the tinted layer blend unit: pixel type, pipeline constants
// and the 8-bit channel arithmetic helpers. No dependencies.
package tlab_pkg;

  localparam int DEFAULT_MAX_DIM = 1024;
  // Register stages from the input item to the result registers.
  localparam int PIPE_DEPTH = 7;

  // Packed RGBA pixel, red in the top byte as in the color registers.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    return 16'(a) * 16'(b);
  endfunction

  // Exact floor(x / 255) for every x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

  // floor((a * (255 - t) + b * t) / 255); the sum never exceeds 255 * 255.
  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] t);
    return div255(mul8(a, 8'd255 - t) + mul8(b, t));
  endfunction

  // Channel k of a packed color: 0 red, 1 green, 2 blue, 3 alpha.
  function automatic logic [7:0] chan(input logic [31:0] packed_color, input int k);
    return packed_color[31 - 8 * k -: 8];
  endfunction

endpackage

>>> rtl/core/tlab_weight_div.sv
// Gradient weight for one axis: floor(pos * 255 / (size - 1)), saturated; 0 when size <= 1.
// Three register stages, a restoring divider at four bits per stage. Uses tlab_pkg.
module tlab_weight_div #(
  parameter int MAX_DIM = tlab_pkg::DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic [9:0]  pos,
  input  logic [10:0] size,
  output logic [7:0]  weight
);
  import tlab_pkg::*;

  localparam int DW = $clog2(MAX_DIM);
  localparam int CW = (DW + 8 > 18) ? DW + 8 : 18;

  logic [17:0]   num;
  logic [DW-1:0] den;
  logic          deg;
  logic          sat;

  logic [17:0]   a_rem;
  logic [DW-1:0] a_den;
  logic          a_deg;
  logic          a_sat;

  logic [17:0]   b_rem_next;
  logic [3:0]    b_q_next;
  logic [17:0]   b_rem;
  logic [DW-1:0] b_den;
  logic [3:0]    b_q;
  logic          b_deg;
  logic          b_sat;

  logic [3:0]    c_q_next;

  assign num = 18'(pos) * 18'd255;

  always_comb begin
    if (32'(size) > 32'(MAX_DIM)) begin
      den = DW'(MAX_DIM - 1);
    end else begin
      den = DW'(32'(size) - 32'd1);
    end
    deg = (size <= 11'd1);
    // A quotient of 256 or more is clamped, so only eight quotient bits remain.
    sat = CW'(num) >= (CW'(den) << 8);
  end

  always_ff @(posedge clk) begin
    a_rem <= num;
    a_den <= den;
    a_deg <= deg;
    a_sat <= sat;
  end

  always_comb begin
    logic [CW-1:0] sh;
    b_rem_next = a_rem;
    b_q_next   = '0;
    for (int i = 0; i < 4; i++) begin
      sh = CW'(a_den) << (7 - i);
      if (CW'(b_rem_next) >= sh) begin
        b_rem_next   = 18'(CW'(b_rem_next) - sh);
        b_q_next[3 - i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_rem <= b_rem_next;
    b_den <= a_den;
    b_q   <= b_q_next;
    b_deg <= a_deg;
    b_sat <= a_sat;
  end

  always_comb begin
    logic [CW-1:0] sh;
    logic [17:0]   rem;
    rem      = b_rem;
    c_q_next = '0;
    for (int i = 0; i < 4; i++) begin
      sh = CW'(b_den) << (3 - i);
      if (CW'(rem) >= sh) begin
        rem = 18'(CW'(rem) - sh);
        c_q_next[3 - i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_deg) begin
      weight <= 8'd0;
    end else if (b_sat) begin
      weight <= 8'd255;
    end else begin
      weight <= {b_q, c_q_next};
    end
  end

endmodule

>>> rtl/core/tlab_gradient.sv
// Gradient tint: bilinear corner color from the weights, then the product
// with the remapped source. Three register stages. Uses tlab_pkg.
module tlab_gradient (
  input  logic            clk,
  input  logic [7:0]      weight_u,
  input  logic [7:0]      weight_v,
  input  tlab_pkg::rgba_t remapped,
  input  tlab_pkg::rgba_t top_left,
  input  tlab_pkg::rgba_t top_right,
  input  tlab_pkg::rgba_t bottom_left,
  input  tlab_pkg::rgba_t bottom_right,
  output tlab_pkg::rgba_t tinted
);
  import tlab_pkg::*;

  logic [3:0][7:0] top_next;
  logic [3:0][7:0] bot_next;
  logic [3:0][7:0] d_top;
  logic [3:0][7:0] d_bot;
  logic [7:0]      d_v;
  logic [31:0]     d_t;

  logic [3:0][7:0] g_next;
  logic [3:0][7:0] e_g;
  logic [31:0]     e_t;

  logic [3:0][7:0] tint_next;

  // Top and bottom rows are interpolated across first.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      top_next[k] = mix8(chan(top_left, k), chan(top_right, k), weight_u);
      bot_next[k] = mix8(chan(bottom_left, k), chan(bottom_right, k), weight_u);
    end
  end

  always_ff @(posedge clk) begin
    d_top <= top_next;
    d_bot <= bot_next;
    d_v   <= weight_v;
    d_t   <= remapped;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      g_next[k] = mix8(d_top[k], d_bot[k], d_v);
    end
  end

  always_ff @(posedge clk) begin
    e_g <= g_next;
    e_t <= d_t;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tint_next[k] = div255(mul8(chan(e_t, k), e_g[k]));
    end
  end

  always_ff @(posedge clk) begin
    tinted <= {tint_next[0], tint_next[1], tint_next[2], tint_next[3]};
  end

endmodule

>>> rtl/core/tlab_blend.sv
// Straight-alpha source-over composite of the tinted pixel onto the
// destination, with the opaque override; result register stage. Uses tlab_pkg.
module tlab_blend (
  input  logic            clk,
  input  tlab_pkg::rgba_t src,
  input  tlab_pkg::rgba_t dst,
  input  logic            force_opaque,
  output tlab_pkg::rgba_t result
);
  import tlab_pkg::*;

  logic [7:0] inv;
  rgba_t      res_next;

  always_comb begin
    inv = 8'd255 - src.alpha;
    if (src.alpha == 8'd0) begin
      res_next = dst;
    end else begin
      res_next.red   = div255(mul8(src.red, src.alpha) + mul8(dst.red, inv));
      res_next.green = div255(mul8(src.green, src.alpha) + mul8(dst.green, inv));
      res_next.blue  = div255(mul8(src.blue, src.alpha) + mul8(dst.blue, inv));
      // The destination term never exceeds inv, so the sum stays within a byte.
      res_next.alpha = src.alpha + div255(mul8(dst.alpha, inv));
    end
    if (force_opaque) begin
      res_next.alpha = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

>>> rtl/core/tinted_layer_alpha_blend_unit.sv
// Tinted layer alpha blend unit, top level: configuration registers, input stage,
// valid chain and payload delay lines; uses tlab_pkg and the tlab_* modules.
// An accepted item has its result on the ports, with done high, after seven
// register stages: weight divider, gradient and blend result register.
// Throughput: one item per clock; busy never rises and the receiver cannot stall.
// Synchronous active-high reset clears the valid chain, presets config registers.
`include "assert_macros.svh"

module tinted_layer_alpha_blend_unit #(
  parameter int MAX_DIM = tlab_pkg::DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  src_red,
  input  logic [7:0]  src_green,
  input  logic [7:0]  src_blue,
  input  logic [7:0]  src_alpha,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_alpha,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  input  logic        force_opaque,
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);
  import tlab_pkg::*;

  typedef enum logic [2:0] {
    REG_BLACK,
    REG_WHITE,
    REG_TOP_LEFT,
    REG_TOP_RIGHT,
    REG_BOTTOM_LEFT,
    REG_BOTTOM_RIGHT,
    REG_WIDTH,
    REG_HEIGHT
  } reg_index_t;

  localparam int DST_TAPS  = PIPE_DEPTH - 1;
  localparam int TINT_TAPS = 3;

  rgba_t       black_color;
  rgba_t       white_color;
  rgba_t       corner_top_left;
  rgba_t       corner_top_right;
  rgba_t       corner_bottom_left;
  rgba_t       corner_bottom_right;
  logic [10:0] image_width;
  logic [10:0] image_height;

  logic [PIPE_DEPTH-1:0] vld;
  rgba_t                 dst_dly [DST_TAPS];
  logic [DST_TAPS-1:0]   frc_dly;
  rgba_t                 tint_dly [TINT_TAPS];
  rgba_t                 remap_next;

  logic [7:0] weight_u;
  logic [7:0] weight_v;
  rgba_t      tinted;
  rgba_t      result;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_color         <= '0;
      white_color         <= '1;
      corner_top_left     <= '1;
      corner_top_right    <= '1;
      corner_bottom_left  <= '1;
      corner_bottom_right <= '1;
      image_width         <= 11'd1;
      image_height        <= 11'd1;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_BLACK:        black_color         <= wr_data;
        REG_WHITE:        white_color         <= wr_data;
        REG_TOP_LEFT:     corner_top_left     <= wr_data;
        REG_TOP_RIGHT:    corner_top_right    <= wr_data;
        REG_BOTTOM_LEFT:  corner_bottom_left  <= wr_data;
        REG_BOTTOM_RIGHT: corner_bottom_right <= wr_data;
        REG_WIDTH:        image_width         <= wr_data[10:0];
        REG_HEIGHT:       image_height        <= wr_data[10:0];
      endcase
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  // First tint step: RGB remapped between black and white, alpha kept.
  always_comb begin
    remap_next.red   = mix8(black_color.red, white_color.red, src_red);
    remap_next.green = mix8(black_color.green, white_color.green, src_green);
    remap_next.blue  = mix8(black_color.blue, white_color.blue, src_blue);
    remap_next.alpha = src_alpha;
  end

  always_ff @(posedge clk) begin
    dst_dly[0]  <= '{red: dst_red, green: dst_green, blue: dst_blue, alpha: dst_alpha};
    frc_dly[0]  <= force_opaque;
    tint_dly[0] <= remap_next;
    for (int i = 1; i < DST_TAPS; i++) begin
      dst_dly[i] <= dst_dly[i-1];
      frc_dly[i] <= frc_dly[i-1];
    end
    for (int i = 1; i < TINT_TAPS; i++) begin
      tint_dly[i] <= tint_dly[i-1];
    end
  end

  tlab_weight_div #(.MAX_DIM(MAX_DIM)) u_weight_x (
    .clk    (clk),
    .pos    (pixel_x),
    .size   (image_width),
    .weight (weight_u)
  );

  tlab_weight_div #(.MAX_DIM(MAX_DIM)) u_weight_y (
    .clk    (clk),
    .pos    (pixel_y),
    .size   (image_height),
    .weight (weight_v)
  );

  tlab_gradient u_gradient (
    .clk          (clk),
    .weight_u     (weight_u),
    .weight_v     (weight_v),
    .remapped     (tint_dly[TINT_TAPS-1]),
    .top_left     (corner_top_left),
    .top_right    (corner_top_right),
    .bottom_left  (corner_bottom_left),
    .bottom_right (corner_bottom_right),
    .tinted       (tinted)
  );

  tlab_blend u_blend (
    .clk          (clk),
    .src          (tinted),
    .dst          (dst_dly[DST_TAPS-1]),
    .force_opaque (frc_dly[DST_TAPS-1]),
    .result       (result)
  );

  assign done      = vld[PIPE_DEPTH-1];
  assign out_red   = result.red;
  assign out_green = result.green;
  assign out_blue  = result.blue;
  assign out_alpha = result.alpha;

  `ASSERT_PROP(a_item_latency, clk, rst, (start && !busy) |-> ##(PIPE_DEPTH) done, "accepted item lost in pipeline")
  `ASSERT_IMPLY(a_no_spurious, clk, rst, done, $past(start && !busy, PIPE_DEPTH), "result without accepted item")
  `ASSERT_PROP(a_force_opaque, clk, rst, (vld[DST_TAPS-1] && frc_dly[DST_TAPS-1]) |=> (out_alpha == 8'hFF), "forced alpha not opaque")

endmodule
